// File: sv/lbd_pkg.sv
package lbd_pkg;

    // Widths of the item fields and of the configuration port.
    localparam int PEC_W     = 8;
    localparam int DT_W      = 10;
    localparam int SUM_W     = 16;
    localparam int TIMER_W   = 16;
    localparam int ATT_W     = 8;
    localparam int STATE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Register reset values.
    localparam logic [SUM_W-1:0]   BREAK_THR_RST  = 16'd25;
    localparam logic [SUM_W-1:0]   START_THR_RST  = 16'd5;
    localparam logic [TIMER_W-1:0] WINDOW_MS_RST  = 16'd4000;
    localparam logic [SUM_W-1:0]   VERIFY_THR_RST = 16'd0;
    localparam logic [ATT_W-1:0]   VERIFY_RDS_RST = 8'd8;
    localparam logic [TIMER_W-1:0] MASK_MS_RST    = 16'd1000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_RDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_MS    = 3'd5;

    typedef enum logic [STATE_W-1:0] {
        MODE_NORMAL  = 3'd0,
        MODE_BREAK   = 3'd1,
        MODE_VERIFY  = 3'd2,
        MODE_SUCCESS = 3'd3,
        MODE_FAILED  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [SUM_W-1:0]   break_threshold;
        logic [SUM_W-1:0]   start_threshold;
        logic [TIMER_W-1:0] window_ms;
        logic [SUM_W-1:0]   verify_threshold;
        logic [ATT_W-1:0]   verify_reads;
        logic [TIMER_W-1:0] startup_mask_ms;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic [PEC_W-1:0]  pec_errors;
        logic [DT_W-1:0]   elapsed_ms;
    } item_t;

    typedef struct packed {
        logic               report_valid;
        logic [STATE_W-1:0] report_state;
        logic [ATT_W-1:0]   report_attempts;
        logic               report_recovered;
        logic               raise_fault;
        logic               clear_fault;
        logic               switch_to_line_b;
        logic               mask_expired;
        logic [STATE_W-1:0] current_state;
    } result_t;

endpackage

// File: sv/lbd_cfg.sv
module lbd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbd_pkg::CFG_DAT_W-1:0]   cfg_wr_data,
    output lbd_pkg::cfg_t                   cfg
);

    lbd_pkg::cfg_t cfg_reg;
    lbd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lbd_pkg::CFG_BREAK_THR:  cfg_next.break_threshold  = cfg_wr_data;
                lbd_pkg::CFG_START_THR:  cfg_next.start_threshold  = cfg_wr_data;
                lbd_pkg::CFG_WINDOW_MS:  cfg_next.window_ms        = cfg_wr_data;
                lbd_pkg::CFG_VERIFY_THR: cfg_next.verify_threshold = cfg_wr_data;
                lbd_pkg::CFG_VERIFY_RDS:
                    cfg_next.verify_reads = cfg_wr_data[lbd_pkg::ATT_W-1:0];
                lbd_pkg::CFG_MASK_MS:    cfg_next.startup_mask_ms  = cfg_wr_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.break_threshold  <= lbd_pkg::BREAK_THR_RST;
            cfg_reg.start_threshold  <= lbd_pkg::START_THR_RST;
            cfg_reg.window_ms        <= lbd_pkg::WINDOW_MS_RST;
            cfg_reg.verify_threshold <= lbd_pkg::VERIFY_THR_RST;
            cfg_reg.verify_reads     <= lbd_pkg::VERIFY_RDS_RST;
            cfg_reg.startup_mask_ms  <= lbd_pkg::MASK_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/lbd_core.sv
module lbd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lbd_pkg::item_t      item,
    input  lbd_pkg::cfg_t       cfg,
    output lbd_pkg::result_t    res
);

    lbd_pkg::mode_t                    mode_reg, mode_next;
    logic [lbd_pkg::SUM_W-1:0]         error_sum_reg, error_sum_next;
    logic                              window_open_reg, window_open_next;
    logic [lbd_pkg::TIMER_W-1:0]       window_left_reg, window_left_next;
    logic [lbd_pkg::TIMER_W-1:0]       mask_left_reg, mask_left_next;
    logic [lbd_pkg::ATT_W-1:0]         attempts_reg, attempts_next;
    logic                              recovered_reg, recovered_next;
    logic                              fail_latched_reg, fail_latched_next;

    logic [lbd_pkg::SUM_W:0]           sum_wide;
    logic [lbd_pkg::SUM_W-1:0]         sum_sat;
    logic [lbd_pkg::TIMER_W-1:0]       dt_ext;
    logic [lbd_pkg::TIMER_W-1:0]       win_dec;
    logic [lbd_pkg::TIMER_W-1:0]       mask_dec;

    // Saturating error sum and the two countdowns, which stop at zero.
    always_comb
    begin
        sum_wide = {1'b0, error_sum_reg}
                 + {{(lbd_pkg::SUM_W+1-lbd_pkg::PEC_W){1'b0}}, item.pec_errors};
        sum_sat  = sum_wide[lbd_pkg::SUM_W] ? {lbd_pkg::SUM_W{1'b1}}
                                            : sum_wide[lbd_pkg::SUM_W-1:0];
        dt_ext   = {{(lbd_pkg::TIMER_W-lbd_pkg::DT_W){1'b0}}, item.elapsed_ms};
        win_dec  = (window_left_reg > dt_ext) ? (window_left_reg - dt_ext) : '0;
        mask_dec = (mask_left_reg > dt_ext) ? (mask_left_reg - dt_ext) : '0;
    end

    always_comb
    begin
        mode_next         = mode_reg;
        error_sum_next    = error_sum_reg;
        window_open_next  = window_open_reg;
        window_left_next  = window_left_reg;
        mask_left_next    = mask_left_reg;
        attempts_next     = attempts_reg;
        recovered_next    = recovered_reg;
        fail_latched_next = fail_latched_reg;
        res               = '0;

        if (item.func)
        begin
            // Reinitialise: every count clears, the mask timer reloads and a normal-state report goes out.
            mode_next         = lbd_pkg::MODE_NORMAL;
            error_sum_next    = '0;
            window_open_next  = 1'b0;
            window_left_next  = '0;
            mask_left_next    = cfg.startup_mask_ms;
            attempts_next     = '0;
            recovered_next    = 1'b0;
            fail_latched_next = 1'b0;
            res.report_valid  = 1'b1;
        end
        else
        begin
            error_sum_next = sum_sat;
            mask_left_next = mask_dec;
            if (window_open_reg)
            begin
                window_left_next = win_dec;
            end

            unique case (mode_reg)
                lbd_pkg::MODE_NORMAL:
                begin
                    if (recovered_reg)
                    begin
                        error_sum_next = '0;
                    end
                    else if (!window_open_reg)
                    begin
                        if (sum_sat > cfg.start_threshold)
                        begin
                            window_open_next = 1'b1;
                            window_left_next = cfg.window_ms;
                        end
                        else
                        begin
                            error_sum_next = '0;
                        end
                    end
                    else if (win_dec == '0)
                    begin
                        if (sum_sat > cfg.break_threshold)
                        begin
                            mode_next       = lbd_pkg::MODE_BREAK;
                            res.raise_fault = 1'b1;
                        end
                        error_sum_next   = '0;
                        window_open_next = 1'b0;
                    end
                end
                lbd_pkg::MODE_BREAK:
                begin
                    res.report_valid     = 1'b1;
                    res.switch_to_line_b = 1'b1;
                    error_sum_next       = '0;
                    mode_next            = lbd_pkg::MODE_VERIFY;
                end
                lbd_pkg::MODE_VERIFY:
                begin
                    res.report_valid = 1'b1;
                    if (attempts_reg >= cfg.verify_reads)
                    begin
                        mode_next = lbd_pkg::MODE_FAILED;
                    end
                    else
                    begin
                        error_sum_next = '0;
                        if (!(sum_sat > cfg.verify_threshold))
                        begin
                            mode_next      = lbd_pkg::MODE_SUCCESS;
                            recovered_next = 1'b1;
                        end
                        attempts_next = attempts_reg
                                      + {{(lbd_pkg::ATT_W-1){1'b0}}, 1'b1};
                    end
                end
                lbd_pkg::MODE_SUCCESS:
                begin
                    res.report_valid = 1'b1;
                    res.clear_fault  = 1'b1;
                    mode_next        = lbd_pkg::MODE_NORMAL;
                end
                lbd_pkg::MODE_FAILED:
                begin
                    if (!fail_latched_reg)
                    begin
                        res.report_valid  = 1'b1;
                        recovered_next    = 1'b0;
                        fail_latched_next = 1'b1;
                    end
                    error_sum_next = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase

            // The report carries the state as it stood before this step.
            if (res.report_valid)
            begin
                res.report_state     = mode_reg;
                res.report_attempts  = attempts_reg;
                res.report_recovered = recovered_reg;
            end
        end

        res.mask_expired  = (mask_left_next == '0);
        res.current_state = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= lbd_pkg::MODE_NORMAL;
            error_sum_reg    <= '0;
            window_open_reg  <= 1'b0;
            window_left_reg  <= '0;
            mask_left_reg    <= lbd_pkg::MASK_MS_RST;
            attempts_reg     <= '0;
            recovered_reg    <= 1'b0;
            fail_latched_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg         <= mode_next;
            error_sum_reg    <= error_sum_next;
            window_open_reg  <= window_open_next;
            window_left_reg  <= window_left_next;
            mask_left_reg    <= mask_left_next;
            attempts_reg     <= attempts_next;
            recovered_reg    <= recovered_next;
            fail_latched_reg <= fail_latched_next;
        end
    end

endmodule

// File: sv/link_break_detect_recover_fsm.sv
// Link break detector and recoverer for a daisy-chained serial link.
// Input channel (in_valid/in_ready): one item per periodic step, carrying
// func (0 step, 1 reinitialise), pec_errors and elapsed_ms.
// Output channel (out_valid/out_ready): exactly one result item per input
// item, in order, with the report fields, the fault and line-switch pulses,
// the startup mask flag and the state after the step.
// An accepted item is held in the input register; when the result register is
// free or is being emptied, the step logic writes it, and out_valid comes from
// the result register. One item per clock is sustained while the receiver
// takes every result: the input register is refilled in the same cycle that it
// hands its item on.
// When the receiver stalls, the result register holds its item, the input
// register holds the next one, and in_ready falls only once both are full.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wr_data
// at any edge; an index beyond the last register is ignored. They should be
// changed only while the block is idle.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the
// state machine to normal with all counts cleared, loads the startup mask
// timer with its reset value and restores every configuration register.
module link_break_detect_recover_fsm (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wr_en,
    input  logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbd_pkg::CFG_DAT_W-1:0]   cfg_wr_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [lbd_pkg::PEC_W-1:0]       pec_errors,
    input  logic [lbd_pkg::DT_W-1:0]        elapsed_ms,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            report_valid,
    output logic [lbd_pkg::STATE_W-1:0]     report_state,
    output logic [lbd_pkg::ATT_W-1:0]       report_attempts,
    output logic                            report_recovered,
    output logic                            raise_fault,
    output logic                            clear_fault,
    output logic                            switch_to_line_b,
    output logic                            mask_expired,
    output logic [lbd_pkg::STATE_W-1:0]     current_state
);

    lbd_pkg::cfg_t      cfg;
    lbd_pkg::item_t     item_reg;
    logic               item_vld_reg;
    lbd_pkg::result_t   step_res;
    lbd_pkg::result_t   res_reg;
    logic               res_vld_reg;
    logic               fire;
    logic               accept;

    // The step fires when an item waits and the result register is free or
    // is being emptied in this cycle.
    assign fire     = item_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || fire;
    assign accept   = in_valid && in_ready;

    lbd_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Input register: payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.func       <= func;
            item_reg.pec_errors <= pec_errors;
            item_reg.elapsed_ms <= elapsed_ms;
        end
    end

    lbd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid        = res_vld_reg;
    assign report_valid     = res_reg.report_valid;
    assign report_state     = res_reg.report_state;
    assign report_attempts  = res_reg.report_attempts;
    assign report_recovered = res_reg.report_recovered;
    assign raise_fault      = res_reg.raise_fault;
    assign clear_fault      = res_reg.clear_fault;
    assign switch_to_line_b = res_reg.switch_to_line_b;
    assign mask_expired     = res_reg.mask_expired;
    assign current_state    = res_reg.current_state;

endmodule

// File: bench/tb_link_break_detect_recover_fsm.sv
`timescale 1ns / 100ps

module tb_link_break_detect_recover_fsm;

    // Longest wait that either side draws before an item.
    localparam int STALL_MAX = 18;
    // The slowest correct stretch with no handshake at all is a full send gap
    // plus a full receive stall, the pass through the input and result registers
    // and a burst of register writes. The limit is many times that stretch.
    localparam int IDLE_LIMIT = 2000;
    // First register index that the block must ignore.
    localparam logic [lbd_pkg::CFG_IDX_W-1:0] CFG_PAST_END = lbd_pkg::CFG_MASK_MS + 3'd1;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [lbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lbd_pkg::CFG_DAT_W-1:0] cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          func = 1'b0;
    logic [lbd_pkg::PEC_W-1:0]     pec_errors = '0;
    logic [lbd_pkg::DT_W-1:0]      elapsed_ms = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          report_valid;
    logic [lbd_pkg::STATE_W-1:0]   report_state;
    logic [lbd_pkg::ATT_W-1:0]     report_attempts;
    logic                          report_recovered;
    logic                          raise_fault;
    logic                          clear_fault;
    logic                          switch_to_line_b;
    logic                          mask_expired;
    logic [lbd_pkg::STATE_W-1:0]   current_state;

    link_break_detect_recover_fsm u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .pec_errors       (pec_errors),
        .elapsed_ms       (elapsed_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .report_valid     (report_valid),
        .report_state     (report_state),
        .report_attempts  (report_attempts),
        .report_recovered (report_recovered),
        .raise_fault      (raise_fault),
        .clear_fault      (clear_fault),
        .switch_to_line_b (switch_to_line_b),
        .mask_expired     (mask_expired),
        .current_state    (current_state)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the link supervisor: settings and state as the block should
    // hold them after every accepted item.
    // ------------------------------------------------------------------
    lbd_pkg::cfg_t                 link_cfg;
    lbd_pkg::mode_t                fsm_mode;
    logic [lbd_pkg::SUM_W-1:0]     err_sum;
    logic                          window_running;
    logic [lbd_pkg::TIMER_W-1:0]   window_remaining;
    logic [lbd_pkg::TIMER_W-1:0]   mask_remaining;
    logic [lbd_pkg::ATT_W-1:0]     verify_count;
    logic                          line_recovered;
    logic                          failure_reported;

    // Status items still owed by the block, oldest first.
    lbd_pkg::result_t link_status_q[$];
    // Items waiting to be offered on the input channel.
    lbd_pkg::item_t   pending_items[$];
    lbd_pkg::item_t   next_item;

    int   items_sent = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   idle_cycles = 0;
    bit   send_quiet = 1'b0;
    bit   recv_quiet = 1'b0;
    logic in_took = 1'b0;
    logic out_took = 1'b0;

    // Countdown timers stop at zero rather than wrapping.
    function automatic logic [lbd_pkg::TIMER_W-1:0] tick_down(
        logic [lbd_pkg::TIMER_W-1:0] left, logic [lbd_pkg::DT_W-1:0] dt);
        logic [lbd_pkg::TIMER_W-1:0] dt_wide;
        dt_wide = {{(lbd_pkg::TIMER_W-lbd_pkg::DT_W){1'b0}}, dt};
        return (left > dt_wide) ? left - dt_wide : '0;
    endfunction

    // Shared by reset and by the init item: every count clears and the
    // startup mask timer reloads from its current setting.
    function automatic void restart_detection();
        fsm_mode         = lbd_pkg::MODE_NORMAL;
        err_sum          = '0;
        window_running   = 1'b0;
        window_remaining = '0;
        mask_remaining   = link_cfg.startup_mask_ms;
        verify_count     = '0;
        line_recovered   = 1'b0;
        failure_reported = 1'b0;
    endfunction

    // A status report carries the state as it stood before the step acts; on an init item, the state after the clear.
    function automatic lbd_pkg::result_t add_status(lbd_pkg::result_t r);
        r.report_valid     = 1'b1;
        r.report_state     = fsm_mode;
        r.report_attempts  = verify_count;
        r.report_recovered = line_recovered;
        return r;
    endfunction

    // Works out the status item that one accepted item must produce and
    // moves the shadow state on.
    function automatic lbd_pkg::result_t link_fsm_step(lbd_pkg::item_t it);
        lbd_pkg::result_t          r;
        logic [lbd_pkg::SUM_W:0]   wide_sum;
        logic                      read_bad;
        r = '0;
        if (it.func)
        begin
            restart_detection();
            r = add_status(r);
        end
        else
        begin
            // The sum saturates rather than wrapping.
            wide_sum = {1'b0, err_sum}
                     + {{(lbd_pkg::SUM_W+1-lbd_pkg::PEC_W){1'b0}}, it.pec_errors};
            err_sum  = wide_sum[lbd_pkg::SUM_W] ? '1 : wide_sum[lbd_pkg::SUM_W-1:0];
            if (window_running)
                window_remaining = tick_down(window_remaining, it.elapsed_ms);
            mask_remaining = tick_down(mask_remaining, it.elapsed_ms);

            case (fsm_mode)
                lbd_pkg::MODE_NORMAL:
                begin
                    if (line_recovered)
                    begin
                        // Once recovered, detection is switched off until the next init.
                        err_sum = '0;
                    end
                    else if (!window_running)
                    begin
                        if (err_sum > link_cfg.start_threshold)
                        begin
                            window_running   = 1'b1;
                            window_remaining = link_cfg.window_ms;
                        end
                        else
                        begin
                            err_sum = '0;
                        end
                    end
                    else if (window_remaining == '0)
                    begin
                        if (err_sum > link_cfg.break_threshold)
                        begin
                            fsm_mode      = lbd_pkg::MODE_BREAK;
                            r.raise_fault = 1'b1;
                        end
                        err_sum        = '0;
                        window_running = 1'b0;
                    end
                end
                lbd_pkg::MODE_BREAK:
                begin
                    r                  = add_status(r);
                    r.switch_to_line_b = 1'b1;
                    err_sum            = '0;
                    fsm_mode           = lbd_pkg::MODE_VERIFY;
                end
                lbd_pkg::MODE_VERIFY:
                begin
                    r = add_status(r);
                    if (verify_count >= link_cfg.verify_reads)
                    begin
                        fsm_mode = lbd_pkg::MODE_FAILED;
                    end
                    else
                    begin
                        read_bad = err_sum > link_cfg.verify_threshold;
                        err_sum  = '0;
                        if (!read_bad)
                        begin
                            fsm_mode       = lbd_pkg::MODE_SUCCESS;
                            line_recovered = 1'b1;
                        end
                        verify_count = verify_count
                                     + {{(lbd_pkg::ATT_W-1){1'b0}}, 1'b1};
                    end
                end
                lbd_pkg::MODE_SUCCESS:
                begin
                    r             = add_status(r);
                    r.clear_fault = 1'b1;
                    fsm_mode      = lbd_pkg::MODE_NORMAL;
                end
                lbd_pkg::MODE_FAILED:
                begin
                    // Failure is reported once and then the machine sits quietly.
                    if (!failure_reported)
                    begin
                        r                = add_status(r);
                        line_recovered   = 1'b0;
                        failure_reported = 1'b1;
                    end
                    err_sum = '0;
                end
                default:
                begin
                end
            endcase
        end
        r.mask_expired  = (mask_remaining == '0);
        r.current_state = fsm_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking.
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            flag_mismatch($sformatf("status item %0d, %s is %0d, should be %0d",
                                    results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers. Items are only queued here; the driver below puts
    // them on the wire.
    // ------------------------------------------------------------------
    function automatic void queue_item(logic f, logic [lbd_pkg::PEC_W-1:0] pec,
                                       logic [lbd_pkg::DT_W-1:0] dt);
        lbd_pkg::item_t it;
        it.func       = f;
        it.pec_errors = pec;
        it.elapsed_ms = dt;
        pending_items.push_back(it);
        items_sent++;
    endfunction

    // One stretch of link life, optionally opened by an init item. The first
    // half of the steps uses one likelihood of heavy error bursts and the
    // second half another, so that a window can build up a break and the
    // verification reads that follow can go either way.
    function automatic void queue_episode(bit with_init, int steps, int early_pct,
                                          int late_pct, int dt_max);
        int k;
        int pct;
        if (with_init)
            queue_item(1'b1, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
        for (k = 0; k < steps; k++)
        begin
            pct = (k < steps / 2) ? early_pct : late_pct;
            queue_item(1'b0,
                       ($urandom_range(0, 99) < pct) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 3)),
                       10'($urandom_range(0, dt_max)));
        end
    endfunction

    // Register writes are driven on the falling edge and land at the next
    // rising edge. The shadow settings follow at once, which is safe because
    // writes only happen while nothing is in flight.
    task automatic write_reg(logic [lbd_pkg::CFG_IDX_W-1:0] idx,
                             logic [lbd_pkg::CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        case (idx)
            lbd_pkg::CFG_BREAK_THR:  link_cfg.break_threshold  = data;
            lbd_pkg::CFG_START_THR:  link_cfg.start_threshold  = data;
            lbd_pkg::CFG_WINDOW_MS:  link_cfg.window_ms        = data;
            lbd_pkg::CFG_VERIFY_THR: link_cfg.verify_threshold = data;
            lbd_pkg::CFG_VERIFY_RDS: link_cfg.verify_reads     = data[lbd_pkg::ATT_W-1:0];
            lbd_pkg::CFG_MASK_MS:    link_cfg.startup_mask_ms  = data;
            default:
            begin
            end
        endcase
    endtask

    task automatic load_settings(logic [lbd_pkg::SUM_W-1:0] brk,
                                 logic [lbd_pkg::SUM_W-1:0] start,
                                 logic [lbd_pkg::TIMER_W-1:0] win,
                                 logic [lbd_pkg::SUM_W-1:0] vthr,
                                 logic [lbd_pkg::ATT_W-1:0] reads,
                                 logic [lbd_pkg::TIMER_W-1:0] mask);
        logic [lbd_pkg::CFG_IDX_W-1:0] spare;
        logic [lbd_pkg::CFG_DAT_W-1:0] junk;
        logic [7:0]                    upper;
        spare = 3'($urandom_range(CFG_PAST_END, CFG_PAST_END + 1));
        junk  = 16'($urandom);
        upper = 8'($urandom_range(0, 255));
        // A write past the last register must leave every setting alone.
        write_reg(spare, junk);
        write_reg(lbd_pkg::CFG_BREAK_THR, brk);
        write_reg(lbd_pkg::CFG_START_THR, start);
        write_reg(lbd_pkg::CFG_WINDOW_MS, win);
        write_reg(lbd_pkg::CFG_VERIFY_THR, vthr);
        // The upper byte is noise; the block keeps only the register's eight bits.
        write_reg(lbd_pkg::CFG_VERIFY_RDS, {upper, reads});
        write_reg(lbd_pkg::CFG_MASK_MS, mask);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Waits until every queued item has come back as a status item. Each
    // item yields exactly one, so the block is idle at that point.
    task automatic drain();
        while (results_seen != items_sent)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver. Fed from pending_items; changes the wires on the falling
    // edge only. Once valid is up it holds, payload and all, until the
    // item has been taken at a rising edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : item_driver
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                func       <= next_item.func;
                pec_errors <= next_item.pec_errors;
                elapsed_ms <= next_item.elapsed_ms;
                in_valid   <= 1'b1;
                // Draw the pause before the following item; now and then
                // switch into or out of a stretch with no pauses at all.
                if ($urandom_range(0, 29) == 0)
                    send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : $urandom_range(0, STALL_MAX);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Every item taken by the block is run through the shadow model at the
    // same edge, and its status item joins the back of the queue.
    always @(posedge clk)
    begin : step_predictor
        lbd_pkg::item_t taken;
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            taken = {func, pec_errors, elapsed_ms};
            link_status_q.push_back(link_fsm_step(taken));
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready is withheld for a random number of cycles after
    // each status item is taken, again with quiet stretches.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : status_sink
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_took)
            begin
                if ($urandom_range(0, 29) == 0)
                    recv_quiet = !recv_quiet;
                recv_stall = recv_quiet ? 0 : $urandom_range(0, STALL_MAX);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Each status item is compared field by field with the oldest one owed.
    always @(posedge clk)
    begin : status_monitor
        lbd_pkg::result_t seen;
        lbd_pkg::result_t owed;
        out_took <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {report_valid, report_state, report_attempts, report_recovered,
                    raise_fault, clear_fault, switch_to_line_b, mask_expired,
                    current_state};
            if (link_status_q.size() == 0)
            begin
                flag_mismatch("status item arrived with none outstanding");
            end
            else
            begin
                owed = link_status_q.pop_front();
                check_field("report_valid", 32'(seen.report_valid),
                            32'(owed.report_valid));
                check_field("report_state", 32'(seen.report_state),
                            32'(owed.report_state));
                check_field("report_attempts", 32'(seen.report_attempts),
                            32'(owed.report_attempts));
                check_field("report_recovered", 32'(seen.report_recovered),
                            32'(owed.report_recovered));
                check_field("raise_fault", 32'(seen.raise_fault),
                            32'(owed.raise_fault));
                check_field("clear_fault", 32'(seen.clear_fault),
                            32'(owed.clear_fault));
                check_field("switch_to_line_b", 32'(seen.switch_to_line_b),
                            32'(owed.switch_to_line_b));
                check_field("mask_expired", 32'(seen.mask_expired),
                            32'(owed.mask_expired));
                check_field("current_state", 32'(seen.current_state),
                            32'(owed.current_state));
                results_seen++;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin : stall_watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence: a directed run at the reset settings, then phases at
    // the extremes of the settings, a sum saturation run, and random phases.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        int phase_start;
        int pick;
        int n;

        // Shadow settings and state start from their reset values.
        link_cfg.break_threshold  = lbd_pkg::BREAK_THR_RST;
        link_cfg.start_threshold  = lbd_pkg::START_THR_RST;
        link_cfg.window_ms        = lbd_pkg::WINDOW_MS_RST;
        link_cfg.verify_threshold = lbd_pkg::VERIFY_THR_RST;
        link_cfg.verify_reads     = lbd_pkg::VERIFY_RDS_RST;
        link_cfg.startup_mask_ms  = lbd_pkg::MASK_MS_RST;
        restart_detection();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed run at the reset settings (break 25, start 5, window
        // 4000 ms, verify threshold 0, eight reads, mask 1000 ms).
        @(posedge clk);
        // Init item whose ignored fields sit at their largest values.
        queue_item(1'b1, 8'hFF, 10'h3FF);
        // A step with nothing in it.
        queue_item(1'b0, 8'h00, 10'h000);
        // Six errors beat the start threshold and open the window.
        queue_item(1'b0, 8'd6, 10'd0);
        // Four full-size steps run the window out with a large sum: break.
        // The startup mask also runs out on the first of them.
        repeat (4) queue_item(1'b0, 8'hFF, 10'h3FF);
        // Break state reports and asks for the second line.
        queue_item(1'b0, 8'd1, 10'd5);
        // First verification read sees errors and fails.
        queue_item(1'b0, 8'd3, 10'd1);
        // Second read is clean, so the link counts as recovered.
        queue_item(1'b0, 8'd0, 10'd1);
        // Success state reports and clears the fault.
        queue_item(1'b0, 8'd0, 10'd0);
        // Recovered: a heavy burst is thrown away and no window opens.
        queue_item(1'b0, 8'd200, 10'd100);
        // Restart; a sum equal to the start threshold does not open a window.
        queue_item(1'b1, 8'd0, 10'd0);
        queue_item(1'b0, 8'd5, 10'd0);
        // A window that closes with its sum under the break threshold.
        queue_item(1'b0, 8'd10, 10'd0);
        repeat (4) queue_item(1'b0, 8'd0, 10'h3FF);
        drain();

        // Every setting at zero: any error opens a window that expires on the
        // next step, breaks at once, and verification fails without a read.
        load_settings('0, '0, '0, '0, '0, '0);
        @(posedge clk);
        for (n = 0; n < 12; n++)
            queue_episode(1'b1, $urandom_range(3, 10), 50, 50,
                          ($urandom_range(0, 1) != 0) ? 1023 : 0);
        drain();

        // Every setting at its top: the window can never open.
        load_settings('1, '1, '1, '1, '1, '1);
        @(posedge clk);
        for (n = 0; n < 8; n++)
            queue_episode(1'b1, $urandom_range(3, 8), 80, 80, 1023);
        drain();

        // Saturation: a long window fills the sum up to its ceiling, which is
        // the only value above a break threshold of 65534.
        load_settings(16'hFFFE, '0, '1, '1, 8'd1, '1);
        @(posedge clk);
        queue_item(1'b1, 8'd0, 10'd0);
        repeat (270) queue_item(1'b0, 8'hFF, 10'($urandom_range(0, 1)));
        repeat (70) queue_item(1'b0, 8'($urandom_range(0, 255)), 10'h3FF);
        queue_episode(1'b0, 6, 20, 20, 1023);
        drain();

        // Random phases. Settings are kept mostly small so that windows,
        // breaks and both endings of verification come up often.
        for (phase = 0; phase < 9; phase++)
        begin
            load_settings(($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 300)),
                          16'($urandom_range(0, 40)),
                          16'($urandom_range(0, 3000)),
                          16'($urandom_range(0, 8)),
                          8'($urandom_range(0, 6)),
                          16'($urandom_range(0, 5000)));
            @(posedge clk);
            phase_start = items_sent;
            while (items_sent - phase_start < 140)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    queue_episode(1'b1, $urandom_range(6, 36), $urandom_range(10, 90),
                                  $urandom_range(0, 40),
                                  ($urandom_range(0, 3) == 0) ? 1023
                                                              : $urandom_range(0, 400));
                else if (pick == 7)
                    // Carries on from wherever the last episode left the machine.
                    queue_episode(1'b0, $urandom_range(3, 20), $urandom_range(0, 100),
                                  $urandom_range(0, 100), $urandom_range(0, 1023));
                else
                    // Unstructured items with the odd stray init among them.
                    repeat ($urandom_range(1, 6))
                        queue_item($urandom_range(0, 7) == 0,
                                   8'($urandom_range(0, 255)),
                                   10'($urandom_range(0, 1023)));
            end
            drain();
        end

        // Give any stray status item time to show itself.
        repeat (4) @(posedge clk);
        if (link_status_q.size() != 0)
            flag_mismatch($sformatf("%0d status items never arrived",
                                    link_status_q.size()));
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
sv/lbd_pkg.sv
sv/lbd_cfg.sv
sv/lbd_core.sv
sv/link_break_detect_recover_fsm.sv
bench/tb_link_break_detect_recover_fsm.sv
